>>> hdl/sedd_pkg.sv
// Shared types, register indexes and reset values for the serpentine dither core.
`default_nettype none

package sedd_pkg;

    // Default geometry limits handed to the top-level parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Fixed field widths
    localparam int PIX_W     = 8;
    localparam int BITS_W    = 4;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CHAN  = 3;

    typedef logic [PIX_W-1:0]               t_pix;
    typedef logic [NUM_CHAN-1:0][PIX_W-1:0] t_rgb;   // [0] red, [1] green, [2] blue
    typedef logic [BITS_W-1:0]              t_bits;
    typedef logic [DIM_W-1:0]               t_dim;
    typedef logic [CFG_IDX_W-1:0]           t_cfg_idx;

    // Register indexes
    localparam t_cfg_idx CFG_RED_BITS     = 3'd0;
    localparam t_cfg_idx CFG_GREEN_BITS   = 3'd1;
    localparam t_cfg_idx CFG_BLUE_BITS    = 3'd2;
    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 3'd3;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 3'd4;

    // Register reset values
    localparam t_bits RST_CHAN_BITS    = 4'd4;
    localparam t_dim  RST_IMAGE_WIDTH  = 11'd320;
    localparam t_dim  RST_IMAGE_HEIGHT = 11'd200;

    // Neighbor errors from the line above, already zeroed where out of range
    typedef struct packed {
        t_pix ahead;
        t_pix center;
        t_pix behind;
    } t_nbr;

endpackage

`default_nettype wire

>>> hdl/sedd_chan.sv
// One color channel: weighted error sum, cap, quantize, new error.
`default_nettype none

module sedd_chan import sedd_pkg::*; (
    input  wire t_pix  i_pix,
    input  wire t_pix  i_prev_err,   // zero at row start
    input  wire t_nbr  i_above,
    input  wire t_bits i_bits,
    output t_pix       o_pix,
    output t_pix       o_err
);

    logic [PIX_W+1:0] sum;
    logic [PIX_W+3:0] w_prev, w_ahead, w_center;
    t_pix             capped;
    t_pix             low_mask;

    always_comb begin
        w_prev   = 12'(i_prev_err) * 12'd7;
        w_ahead  = 12'(i_above.ahead) * 12'd3;
        w_center = 12'(i_above.center) * 12'd5;
        // each term truncated on its own before the sum
        sum = 10'(i_pix)
            + 10'(w_prev[PIX_W+3:4])
            + 10'(w_ahead[PIX_W+3:4])
            + 10'(w_center[PIX_W+3:4])
            + 10'(i_above.behind[PIX_W-1:4]);
        capped   = (sum > 10'd255) ? 8'hFF : sum[PIX_W-1:0];
        // more than eight kept bits acts as eight
        low_mask = (i_bits >= 4'd8) ? 8'h00 : (8'hFF >> i_bits);
        o_pix    = capped & ~low_mask;
        o_err    = capped & low_mask;
    end

endmodule

`default_nettype wire

>>> hdl/serpentine_error_diffusion_dither_core.sv
// Top level of the serpentine Floyd-Steinberg dither core.
// Takes one 8-bit RGB pixel per clock unless held off, in serpentine order
// (even rows left to right, odd rows right to left), and returns one dithered
// pixel per accepted request through stage 1 and the output register, with
// tlast marking the end of a row and tuser the end of the frame. Sustained
// rate is one pixel per clock while not stalled: the line store is read for
// the above-center and above-ahead errors in the cycle a request is taken, and
// stage 1 then sums, quantizes and writes the pixel's error back; the above-behind term is
// the previous pixel's above-center value kept in a register, and the
// previous-pixel error is a register fed straight back, so no
// read-modify-write waits on another. A width write can move the current
// pixel off its predecessor's neighbor, so the cycle after a width write the
// input is held off for one cycle while the above-behind entry is fetched
// again from the line store on the center read port.
// The only same-entry overlap, at a row turn where the new row's first pixel
// reads the entry the last pixel of the old row writes in that same cycle,
// is forwarded. The line store (two lines, one per row parity) has no reset
// and no clearing pass: the first row of a frame masks its reads, so it
// needs no valid bits. Channel bit depths and frame size are written through
// the config port while the core is idle, a rule the core leaves to the user to
// keep; width and height are saturated to 1..MAX_WIDTH and 1..MAX_HEIGHT, and
// counters left beyond a shrunk size are pulled back to the last column or row.
`default_nettype none

module serpentine_error_diffusion_dither_core import sedd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // config write port
    input  wire        i_cfg_wr_en,
    input  wire t_cfg_idx i_cfg_index,
    input  wire t_dim  i_cfg_wdata,
    // pixel in
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire [23:0] i_s_axis_tdata,   // red_in, green_in, blue_in
    // pixel out
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // red_out, green_out, blue_out
    output logic       o_m_axis_tlast,   // row_end
    output logic       o_m_axis_tuser    // frame_end
);

    localparam int X_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int Y_W   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XE_W  = (X_W + 1 > DIM_W) ? X_W + 1 : DIM_W;
    localparam int YE_W  = (Y_W + 1 > DIM_W) ? Y_W + 1 : DIM_W;
    localparam int A_W   = X_W + 1;
    localparam int DEPTH = 2 ** A_W;

    // ---------------- configuration registers ----------------
    t_bits r_red_bits, r_green_bits, r_blue_bits;
    t_dim  r_image_width, r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_bits     <= RST_CHAN_BITS;
            r_green_bits   <= RST_CHAN_BITS;
            r_blue_bits    <= RST_CHAN_BITS;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_RED_BITS:     r_red_bits     <= i_cfg_wdata[BITS_W-1:0];
                CFG_GREEN_BITS:   r_green_bits   <= i_cfg_wdata[BITS_W-1:0];
                CFG_BLUE_BITS:    r_blue_bits    <= i_cfg_wdata[BITS_W-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- effective geometry ----------------
    logic [XE_W-1:0] w_ext;
    logic [YE_W-1:0] h_ext;
    logic [X_W-1:0]  w_m1;   // last column
    logic [Y_W-1:0]  h_m1;   // last row

    always_comb begin
        w_ext = XE_W'(r_image_width);
        h_ext = YE_W'(r_image_height);
        if (w_ext == '0)
            w_m1 = '0;
        else if (w_ext > XE_W'(MAX_WIDTH))
            w_m1 = X_W'(MAX_WIDTH - 1);
        else
            w_m1 = X_W'(w_ext - XE_W'(1));
        if (h_ext == '0)
            h_m1 = '0;
        else if (h_ext > YE_W'(MAX_HEIGHT))
            h_m1 = Y_W'(MAX_HEIGHT - 1);
        else
            h_m1 = Y_W'(h_ext - YE_W'(1));
    end

    // ---------------- position counters ----------------
    logic [X_W-1:0] r_col;
    logic [Y_W-1:0] r_row;
    logic           r_parity;   // 1: odd row, right to left

    logic [X_W-1:0] col_sat, pos_x, pos_ahead, pos_behind;
    logic [Y_W-1:0] row_sat;
    logic           row_end, frame_end;

    always_comb begin
        col_sat    = (r_col > w_m1) ? w_m1 : r_col;
        row_sat    = (r_row > h_m1) ? h_m1 : r_row;
        pos_x      = r_parity ? (w_m1 - col_sat) : col_sat;
        pos_ahead  = r_parity ? (pos_x - X_W'(1)) : (pos_x + X_W'(1));
        pos_behind = r_parity ? (pos_x + X_W'(1)) : (pos_x - X_W'(1));
        row_end    = (col_sat == w_m1);
        frame_end  = row_end && (row_sat == h_m1);
    end

    logic accept;
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_parity <= 1'b0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                if (frame_end) begin
                    r_row    <= '0;
                    r_parity <= 1'b0;
                end else begin
                    r_row    <= row_sat + Y_W'(1);
                    r_parity <= ~row_sat[0];
                end
            end else begin
                r_col <= col_sat + X_W'(1);
            end
        end
    end

    // ---------------- stage 1: line store read ----------------
    logic           r1_valid;
    t_rgb           r1_pix;
    logic [X_W-1:0] r1_x;
    logic           r1_line;
    logic           r1_first_col;   // no previous pixel, no above-behind
    logic           r1_above_ok;    // not the first row
    logic           r1_ahead_ok;    // above-ahead lies inside the row
    logic           r1_row_end, r1_frame_end;
    logic           r1_fwd_center, r1_fwd_ahead;
    t_rgb           r1_fwd_data;

    logic adv1;   // stage 1 result moves to the output register
    logic r_out_valid;
    logic r_refetch;     // width just written: fetch the above-behind entry
    logic r_refetch_d;   // fetched entry waits in r_rd_center

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refetch   <= 1'b0;
            r_refetch_d <= 1'b0;
        end else begin
            r_refetch   <= i_cfg_wr_en && (i_cfg_index == CFG_IMAGE_WIDTH);
            r_refetch_d <= r_refetch;
        end
    end

    assign adv1            = r1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_refetch && (!r1_valid || adv1);

    // line store: entry {row parity, column}
    t_rgb           mem [DEPTH];
    t_rgb           r_rd_center, r_rd_ahead;
    logic [A_W-1:0] rd_center_addr, rd_ahead_addr, wr_addr;
    t_rgb           wr_data;

    assign rd_center_addr = r_refetch ? {~r_parity, pos_behind} : {~r_parity, pos_x};
    assign rd_ahead_addr  = {~r_parity, pos_ahead};
    assign wr_addr        = {r1_line, r1_x};

    always_ff @(posedge i_clk) begin
        if (adv1)
            mem[wr_addr] <= wr_data;
        if (accept || r_refetch)
            r_rd_center <= mem[rd_center_addr];
        if (accept)
            r_rd_ahead  <= mem[rd_ahead_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r1_valid <= 1'b0;
        else if (accept)
            r1_valid <= 1'b1;
        else if (adv1)
            r1_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_pix        <= i_s_axis_tdata;
            r1_x          <= pos_x;
            r1_line       <= r_parity;
            r1_first_col  <= (col_sat == '0);
            r1_above_ok   <= (row_sat != '0);
            r1_ahead_ok   <= !row_end;
            r1_row_end    <= row_end;
            r1_frame_end  <= frame_end;
            // read and write of the same entry in one cycle: take the new data
            r1_fwd_center <= adv1 && (wr_addr == rd_center_addr);
            r1_fwd_ahead  <= adv1 && (wr_addr == rd_ahead_addr);
            r1_fwd_data   <= wr_data;
        end
    end

    // ---------------- stage 1: diffusion ----------------
    t_rgb  r_prev_err;     // error of the previous pixel in the row
    t_rgb  r_last_center;  // previous pixel's above-center = this one's above-behind
    t_rgb  above_center, above_ahead, above_behind, prev_err;
    t_rgb  res_pix;
    t_bits chan_bits [NUM_CHAN];

    always_comb begin
        if (!r1_above_ok)
            above_center = '0;
        else if (r1_fwd_center)
            above_center = r1_fwd_data;
        else
            above_center = r_rd_center;
        if (!r1_above_ok || !r1_ahead_ok)
            above_ahead = '0;
        else if (r1_fwd_ahead)
            above_ahead = r1_fwd_data;
        else
            above_ahead = r_rd_ahead;
        above_behind = (r1_first_col || !r1_above_ok) ? '0 : r_last_center;
        prev_err     = r1_first_col ? '0 : r_prev_err;
    end

    assign chan_bits[0] = r_red_bits;
    assign chan_bits[1] = r_green_bits;
    assign chan_bits[2] = r_blue_bits;

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
        t_nbr nbr;
        assign nbr = '{ahead: above_ahead[c], center: above_center[c],
                       behind: above_behind[c]};
        sedd_chan u_chan (
            .i_pix      (r1_pix[c]),
            .i_prev_err (prev_err[c]),
            .i_above    (nbr),
            .i_bits     (chan_bits[c]),
            .o_pix      (res_pix[c]),
            .o_err      (wr_data[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv1)
            r_prev_err <= wr_data;
        if (r_refetch_d)
            r_last_center <= r_rd_center;
        else if (adv1)
            r_last_center <= above_center;
    end

    // ---------------- output register ----------------
    t_rgb r_out_pix;
    logic r_out_last, r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (adv1)
            r_out_valid <= 1'b1;
        else if (i_m_axis_tready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_out_pix  <= res_pix;
            r_out_last <= r1_row_end;
            r_out_user <= r1_frame_end;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_pix;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

>>> hdl/sedd_checker.sv
// Port-level checks for the dither core, bound to the top level.
`default_nettype none

module sedd_checker import sedd_pkg::*; (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_axis_tvalid,
    input wire        o_s_axis_tready,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [23:0] o_m_axis_tdata,
    input wire        o_m_axis_tlast,
    input wire        o_m_axis_tuser
);

    logic       in_acc, out_acc;
    logic [2:0] r_pending;   // requests taken, results not yet delivered

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_pending <= '0;
        else
            r_pending <= r_pending + 3'(in_acc) - 3'(out_acc);
    end

    // frame end always falls on a row end
    a_frame_on_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("frame end without row end");

    // no result without a request in flight
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_pending != 3'd0))
        else $error("result with no pending request");

    // two stages deep: never more than two in flight
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd2)
        else $error("too many requests in flight");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind serpentine_error_diffusion_dither_core sedd_checker u_sedd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
